FILE: hdl/ant_pkg.sv
`default_nettype none

package ant_pkg;

  localparam int ENTRIES_DEF     = 256;
  localparam int INDEX_BITS_DEF  = 10;
  localparam int NUMBER_BITS_DEF = 16;

  localparam int ACT_W      = 2;
  localparam int FIELD_W    = 10;
  localparam int ARC_W      = 16;
  localparam int STAT_W     = 2;
  localparam int START_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD      = 2'd0,
    ACT_LOOKUP   = 2'd1,
    ACT_RM_PLACE = 2'd2,
    ACT_RM_TRANS = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_FOUND  = 2'd0,
    STAT_NEW    = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  localparam logic [0:0] REG_START = 1'b0;

endpackage

`default_nettype wire

FILE: hdl/ant_ifs.sv
`default_nettype none

interface ant_in_if import ant_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [FIELD_W-1:0] place;
  logic [FIELD_W-1:0] transition;

  modport source (output valid, output action, output place, output transition, input ready);
  modport sink   (input valid, input action, input place, input transition, output ready);
endinterface

interface ant_out_if import ant_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ARC_W-1:0]  arc_number;
  logic [STAT_W-1:0] status;

  modport source (output valid, output arc_number, output status, input ready);
  modport sink   (input valid, input arc_number, input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/arc_number_table.sv
`default_nettype none

// Channel   Dir  Transfer when                 Payload
// in_ch     in   in_ch.valid && in_ch.ready     action, place, transition
// out_ch    out  out_ch.valid && out_ch.ready   arc_number, status
// APB       in   psel && penable && pwrite      start_number at byte address 0
//
// Each request is accepted in the idle state; a scan then streams every table entry
// through the single read port of the entry memory and drains the last read, and a
// finish step closes the request.
// After reset a clearing pass writes every entry invalid; no request is accepted
// meanwhile.
// A new request is accepted while a result waits in the output register; its finish
// cycle waits until that result's transfer is done.

module arc_number_table import ant_pkg::*; #(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ant_in_if.sink                     in_ch,
  ant_out_if.source                  out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = 1 + 2 * INDEX_BITS + NUMBER_BITS;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES);
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(ENTRIES - 1);

  logic [WORD_W-1:0] entry_mem [ENTRIES];

  state_t                  state_r, state_nxt;
  action_t                 act_r;
  logic [INDEX_BITS-1:0]   place_r, trans_r;
  logic [CNT_W-1:0]        issue_cnt_r, issue_cnt_nxt;
  logic [IDX_W-1:0]        proc_idx_r, proc_idx_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [WORD_W-1:0]       rd_data_r;
  logic                    hit_r, hit_nxt;
  logic [NUMBER_BITS-1:0]  hit_num_r, hit_num_nxt;
  logic                    free_r, free_nxt;
  logic [IDX_W-1:0]        free_idx_r, free_idx_nxt;
  logic                    removed_r, removed_nxt;
  logic [IDX_W-1:0]        clr_idx_r, clr_idx_nxt;
  logic [START_W-1:0]      start_r, start_nxt;
  logic [NUMBER_BITS-1:0]  next_num_r, next_num_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ARC_W-1:0]        out_num_r, out_num_nxt;
  status_t                 out_stat_r, out_stat_nxt;

  logic                    in_ready, in_acc;
  logic                    rd_en, wr_en;
  logic [IDX_W-1:0]        rd_addr, wr_addr;
  logic [WORD_W-1:0]       wr_data;
  logic                    cfg_wr, cfg_sel;

  logic [FIELD_W+INDEX_BITS-1:0]  place_wide, trans_wide;
  logic [START_W+NUMBER_BITS-1:0] start_wide;
  logic [NUMBER_BITS+ARC_W-1:0]   hit_num_wide, next_num_wide;

  logic                    ent_vld, place_eq, trans_eq;
  logic [INDEX_BITS-1:0]   ent_place, ent_trans;
  logic [NUMBER_BITS-1:0]  ent_num;

  assign place_wide    = {INDEX_BITS'(0), in_ch.place};
  assign trans_wide    = {INDEX_BITS'(0), in_ch.transition};
  assign start_wide    = {NUMBER_BITS'(0), pwdata[START_W-1:0]};
  assign hit_num_wide  = {ARC_W'(0), hit_num_r};
  assign next_num_wide = {ARC_W'(0), next_num_r};

  assign ent_vld   = rd_data_r[WORD_W-1];
  assign ent_place = rd_data_r[WORD_W-2 -: INDEX_BITS];
  assign ent_trans = rd_data_r[NUMBER_BITS +: INDEX_BITS];
  assign ent_num   = rd_data_r[NUMBER_BITS-1:0];
  assign place_eq  = (ent_place == place_r);
  assign trans_eq  = (ent_trans == trans_r);

  assign cfg_sel = (paddr[CFG_ADDR_W-1:2] == REG_START);
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? CFG_DATA_W'(start_r) : '0;

  assign in_ch.ready       = in_ready;
  assign in_acc            = in_ch.valid && in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.arc_number = out_num_r;
  assign out_ch.status     = out_stat_r;

  always_comb begin
    state_nxt     = state_r;
    issue_cnt_nxt = issue_cnt_r;
    proc_idx_nxt  = proc_idx_r;
    rd_vld_nxt    = rd_vld_r;
    hit_nxt       = hit_r;
    hit_num_nxt   = hit_num_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    removed_nxt   = removed_r;
    clr_idx_nxt   = clr_idx_r;
    start_nxt     = start_r;
    next_num_nxt  = next_num_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_num_nxt   = out_num_r;
    out_stat_nxt  = out_stat_r;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = issue_cnt_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = proc_idx_r;
    wr_data       = {1'b0, rd_data_r[WORD_W-2:0]};

    unique case (state_r)
      S_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_data     = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt     = S_SCAN;
          issue_cnt_nxt = '0;
          rd_vld_nxt    = 1'b0;
          hit_nxt       = 1'b0;
          free_nxt      = 1'b0;
          removed_nxt   = 1'b0;
        end
      end
      S_SCAN: begin
        rd_vld_nxt = 1'b0;
        if (issue_cnt_r != LAST_CNT) begin
          rd_en         = 1'b1;
          rd_vld_nxt    = 1'b1;
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          proc_idx_nxt  = issue_cnt_r[IDX_W-1:0];
        end
        if (rd_vld_r) begin
          if (act_r == ACT_ADD || act_r == ACT_LOOKUP) begin
            if (ent_vld && place_eq && trans_eq && !hit_r) begin
              hit_nxt     = 1'b1;
              hit_num_nxt = ent_num;
            end
            if (!ent_vld && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = proc_idx_r;
            end
          end else if (ent_vld && ((act_r == ACT_RM_PLACE && place_eq) ||
                                   (act_r == ACT_RM_TRANS && trans_eq))) begin
            wr_en       = 1'b1;
            removed_nxt = 1'b1;
          end
        end
        if (issue_cnt_r == LAST_CNT && !rd_vld_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_num_nxt   = '0;
          unique case (act_r)
            ACT_ADD: begin
              if (hit_r) begin
                out_num_nxt  = hit_num_wide[ARC_W-1:0];
                out_stat_nxt = STAT_FOUND;
              end else if (!free_r || next_num_r == '0) begin
                out_stat_nxt = STAT_FULL;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = free_idx_r;
                wr_data      = {1'b1, place_r, trans_r, next_num_r};
                out_num_nxt  = next_num_wide[ARC_W-1:0];
                out_stat_nxt = STAT_NEW;
                next_num_nxt = next_num_r + 1'b1;
              end
            end
            ACT_LOOKUP: begin
              out_num_nxt  = hit_r ? hit_num_wide[ARC_W-1:0] : '0;
              out_stat_nxt = hit_r ? STAT_FOUND : STAT_ABSENT;
            end
            ACT_RM_PLACE, ACT_RM_TRANS: begin
              out_stat_nxt = removed_r ? STAT_FOUND : STAT_ABSENT;
            end
          endcase
        end
      end
    endcase

    if (cfg_wr) begin
      start_nxt    = pwdata[START_W-1:0];
      next_num_nxt = start_wide[NUMBER_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      issue_cnt_r <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      removed_r   <= 1'b0;
      start_r     <= START_W'(1);
      next_num_r  <= NUMBER_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      removed_r   <= removed_nxt;
      start_r     <= start_nxt;
      next_num_r  <= next_num_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= proc_idx_nxt;
    hit_num_r  <= hit_num_nxt;
    free_idx_r <= free_idx_nxt;
    out_num_r  <= out_num_nxt;
    out_stat_r <= out_stat_nxt;
    if (in_acc) begin
      act_r   <= action_t'(in_ch.action);
      place_r <= place_wide[INDEX_BITS-1:0];
      trans_r <= trans_wide[INDEX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= entry_mem[rd_addr];
    end
  end

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("Entry memory written and read at the same address.");

  a_no_zero_number: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && wr_data[WORD_W-1]) |-> (wr_data[NUMBER_BITS-1:0] != '0))
    else $error("A valid entry was stored with arc number zero.");

  a_scan_only_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == S_SCAN) |-> !wr_data[WORD_W-1])
    else $error("A scan write left an entry valid.");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("A result appeared outside the finish step.");

endmodule

`default_nettype wire
